// ----- rtl/core/decimal96_compare_macros.svh -----
// Assertion macros shared by the decimal96_compare RTL.
// Each macro expects signals named clock and reset in the using module.
`ifndef DECIMAL96_COMPARE_MACROS_SVH
`define DECIMAL96_COMPARE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define D96C_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define D96C_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/d96c_pkg.sv -----
// Package for decimal96_compare: payload structs, pipeline struct and constants.
// Used by d96c_cell, d96c_cmp and decimal96_compare; depends on nothing.
`default_nettype none

package d96c_pkg;

   localparam int MAG_W       = 96;
   localparam int MAG_LOW_W   = 64;
   localparam int MAG_HIGH_W  = 32;
   localparam int SCALE_W     = 5;
   localparam int MAX_SCALE   = 28;
   localparam int GUARD_W     = 4;

   typedef struct packed {
      logic [MAG_LOW_W-1:0]  left_mag_low;
      logic [MAG_HIGH_W-1:0] left_mag_high;
      logic [SCALE_W-1:0]    left_scale;
      logic                  left_negative;
      logic [MAG_LOW_W-1:0]  right_mag_low;
      logic [MAG_HIGH_W-1:0] right_mag_high;
      logic [SCALE_W-1:0]    right_scale;
      logic                  right_negative;
   } req_type;

   typedef struct packed {
      logic is_equal;
      logic is_not_equal;
      logic is_less;
      logic is_greater;
      logic is_less_or_equal;
      logic is_greater_or_equal;
   } rsp_type;

   typedef struct packed {
      logic [MAG_W-1:0]   left_mag;
      logic [MAG_W-1:0]   right_mag;
      logic [SCALE_W-1:0] steps;
      logic               align_left;
      logic               overflow;
      logic               both_zero;
      logic               left_negative;
      logic               right_negative;
   } pipe_type;

endpackage

`default_nettype wire

// ----- rtl/core/d96c_cell.sv -----
// One times-ten alignment cell of the decimal96_compare chain.
// Depends on d96c_pkg for the pipeline struct.
`default_nettype none

module d96c_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire d96c_pkg::pipe_type in_pipe,
   output logic                    out_valid,
   output d96c_pkg::pipe_type      out_pipe
);

   localparam int PROD_W = d96c_pkg::MAG_W + d96c_pkg::GUARD_W;

   logic               valid_ff;
   d96c_pkg::pipe_type pipe_ff;
   d96c_pkg::pipe_type pipe_in;
   logic [d96c_pkg::MAG_W-1:0] mag_sel;
   logic [PROD_W-1:0]          mag_ext;
   logic [PROD_W-1:0]          product;

   always_comb begin
      mag_sel = in_pipe.align_left ? in_pipe.left_mag : in_pipe.right_mag;
      mag_ext = {{d96c_pkg::GUARD_W{1'b0}}, mag_sel};
      product = (mag_ext << 3) + (mag_ext << 1);
      pipe_in = in_pipe;
      if (in_pipe.steps != '0 && !in_pipe.overflow) begin
         if (product[PROD_W-1:d96c_pkg::MAG_W] != '0) begin
            pipe_in.overflow = 1'b1;
         end else begin
            pipe_in.steps = in_pipe.steps - d96c_pkg::SCALE_W'(1);
            if (in_pipe.align_left) begin
               pipe_in.left_mag = product[d96c_pkg::MAG_W-1:0];
            end else begin
               pipe_in.right_mag = product[d96c_pkg::MAG_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      pipe_ff <= pipe_in;
   end

   assign out_valid = valid_ff;
   assign out_pipe  = pipe_ff;

endmodule

`default_nettype wire

// ----- rtl/core/d96c_cmp.sv -----
// Final compare stage of decimal96_compare: orders the aligned magnitudes
// and registers all six relations. Depends on d96c_pkg.
`default_nettype none

module d96c_cmp (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire d96c_pkg::pipe_type in_pipe,
   output logic                    rsp_valid,
   output d96c_pkg::rsp_type       rsp_data
);

   logic              valid_ff;
   d96c_pkg::rsp_type rsp_ff;
   d96c_pkg::rsp_type rsp_in;
   logic              mag_gt;
   logic              mag_lt;
   logic              less;
   logic              greater;

   always_comb begin
      if (in_pipe.overflow) begin
         mag_gt = in_pipe.align_left;
         mag_lt = !in_pipe.align_left;
      end else begin
         mag_gt = in_pipe.left_mag > in_pipe.right_mag;
         mag_lt = in_pipe.left_mag < in_pipe.right_mag;
      end
      if (in_pipe.both_zero) begin
         less    = 1'b0;
         greater = 1'b0;
      end else if (in_pipe.left_negative != in_pipe.right_negative) begin
         less    = in_pipe.left_negative;
         greater = !in_pipe.left_negative;
      end else if (in_pipe.left_negative) begin
         less    = mag_gt;
         greater = mag_lt;
      end else begin
         less    = mag_lt;
         greater = mag_gt;
      end
      rsp_in.is_equal            = !less && !greater;
      rsp_in.is_not_equal        = less || greater;
      rsp_in.is_less             = less;
      rsp_in.is_greater          = greater;
      rsp_in.is_less_or_equal    = !greater;
      rsp_in.is_greater_or_equal = !less;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ----- rtl/core/decimal96_compare.sv -----
// Top level of decimal96_compare: input register, chain of times-ten cells
// and compare stage. Depends on d96c_pkg, d96c_cell, d96c_cmp and the macro header.
//
// Channel   Ports                      Handshake
// request   start, busy, req_data      transfer when start is high and busy is low
// response  rsp_valid, rsp_data        one-cycle strobe, always taken
//
// A new compare is taken every cycle once busy is low; each result is registered in
// one input register, MAX_SCALE alignment cells and the compare register in turn.
// Each cell does at most one times-ten step of one magnitude.
// Busy is high during reset and for the first cycle after it, then stays low.
// The response side cannot stall, so the chain never holds.
`default_nettype none
`include "decimal96_compare_macros.svh"

module decimal96_compare #(
   parameter int MAX_SCALE = d96c_pkg::MAX_SCALE
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire d96c_pkg::req_type req_data,
   output logic                   rsp_valid,
   output d96c_pkg::rsp_type      rsp_data
);

   localparam int LATENCY = MAX_SCALE + 2;
   localparam logic [d96c_pkg::SCALE_W-1:0] SCALE_CAP = d96c_pkg::SCALE_W'(MAX_SCALE);

   logic                        busy_ff;
   logic                        transfer;
   logic [d96c_pkg::SCALE_W-1:0] left_scale;
   logic [d96c_pkg::SCALE_W-1:0] right_scale;
   d96c_pkg::pipe_type          prep_in;
   logic                        stage_valid [0:MAX_SCALE];
   d96c_pkg::pipe_type          stage_pipe  [0:MAX_SCALE];
   logic                        valid_ff;
   d96c_pkg::pipe_type          pipe_ff;
   logic                        order_onehot;
   logic                        derived_ok;

   assign transfer = start && !busy_ff;
   assign busy     = busy_ff;

   always_comb begin
      left_scale  = (req_data.left_scale > SCALE_CAP) ? SCALE_CAP : req_data.left_scale;
      right_scale = (req_data.right_scale > SCALE_CAP) ? SCALE_CAP : req_data.right_scale;
      prep_in.left_mag       = {req_data.left_mag_high, req_data.left_mag_low};
      prep_in.right_mag      = {req_data.right_mag_high, req_data.right_mag_low};
      prep_in.align_left     = left_scale < right_scale;
      prep_in.steps          = prep_in.align_left ? (right_scale - left_scale)
                                                  : (left_scale - right_scale);
      prep_in.overflow       = 1'b0;
      prep_in.both_zero      = (prep_in.left_mag == '0) && (prep_in.right_mag == '0);
      prep_in.left_negative  = req_data.left_negative;
      prep_in.right_negative = req_data.right_negative;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= 1'b0;
         valid_ff <= transfer;
      end
      pipe_ff <= prep_in;
   end

   assign stage_valid[0] = valid_ff;
   assign stage_pipe[0]  = pipe_ff;

   for (genvar i = 0; i < MAX_SCALE; i++) begin : g_cell
      d96c_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[i]),
         .in_pipe   (stage_pipe[i]),
         .out_valid (stage_valid[i+1]),
         .out_pipe  (stage_pipe[i+1])
      );
   end

   d96c_cmp u_cmp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[MAX_SCALE]),
      .in_pipe   (stage_pipe[MAX_SCALE]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign order_onehot = $onehot({rsp_data.is_less, rsp_data.is_equal, rsp_data.is_greater});
   assign derived_ok   = (rsp_data.is_not_equal != rsp_data.is_equal) &&
      (rsp_data.is_less_or_equal == (rsp_data.is_less || rsp_data.is_equal)) &&
      (rsp_data.is_greater_or_equal == (rsp_data.is_greater || rsp_data.is_equal));

   `D96C_ASSERT_IMPL(a_latency, rsp_valid, $past(transfer, LATENCY), "strobe without a transfer")
   `D96C_ASSERT_IMPL(a_one_order, rsp_valid, order_onehot, "order relations are not one-hot")
   `D96C_ASSERT_IMPL(a_derived, rsp_valid, derived_ok, "derived relations disagree")
   `D96C_ASSERT_NEXT(a_busy_clears, busy, !busy, "busy stays high after reset")

endmodule

`default_nettype wire
